// File: design/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // built depth of the window and sample width
    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;

    // width of the window length register
    localparam int WLEN_W = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(3);

    // cell index / age width and a count that can hold the depth itself
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    // stream data width, padded to whole bytes
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // what a cell shows its neighbors
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic [IDX_W-1:0]        age;
        logic                    valid;
        logic                    le;     // valid and not greater than the new sample
    } swm_view_t;

    // broadcast control for the whole row of cells
    typedef struct packed {
        logic                    load;     // sample transfer this cycle
        logic                    clear;    // empty the window
        logic                    full;     // window holds k entries before this sample
        logic [IDX_W-1:0]        age_last; // age of the oldest entry, k-1
        logic [SAMPLE_WIDTH-1:0] sample;
    } swm_ctrl_t;

endpackage

`default_nettype wire

// File: design/sliding_window_median_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Running lower-median filter over a stream of signed samples.
// Input stream s_axis: one sample per transfer in s_axis_tdata.
// Output stream m_axis: one median per transfer in m_axis_tdata, given for
// every sample once the window holds window_length samples; the first
// window_length-1 samples after reset or a length write give no output.
// cfg_wr_en / cfg_wr_data write the window length (1..64, 0 acts as 1,
// larger values act as 64) and empty the window; write only while idle.
// A row of 64 cells holds the window in sorted order with age tags; each
// transfer inserts the new sample and, once the window is full, evicts the
// oldest entry, so a sample is taken every cycle while s_axis_tready is high.
// The median of a sample reaches m_axis_tdata through the cell update, then
// the median select into the output register once that register is free.
// Reset empties the window and sets the length to 3; no output is pending.
// When m_axis_tready is low, one result waits in the output register and one
// more behind it; with both held, s_axis_tready drops until the output moves.

module sliding_window_median_core
    import swm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // sample
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // median
    input  wire logic               cfg_wr_en,
    input  wire logic [WLEN_W-1:0]  cfg_wr_data     // window_length
);

    logic [WLEN_W-1:0]       wlen_reg;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        keff;
    logic                    load, full, emit, can_accept;
    swm_ctrl_t               ctrl;
    swm_view_t               old_view [WINDOW_MAX];
    swm_view_t               ev_view  [WINDOW_MAX];
    swm_view_t               dn_view  [WINDOW_MAX];
    swm_view_t               up_view  [WINDOW_MAX];
    logic                    ev_chain [WINDOW_MAX];
    logic                    dn_ev    [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]   valid_vec;
    logic [SAMPLE_WIDTH-1:0] median;

    // effective window length
    always_comb
    begin
        priority if (wlen_reg == '0)
        begin
            keff = CNT_W'(1);
        end
        else if (32'(wlen_reg) > 32'(WINDOW_MAX))
        begin
            keff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            keff = CNT_W'(wlen_reg);
        end
    end

    assign s_axis_tready = can_accept;
    assign load = s_axis_tvalid && can_accept;
    assign full = (fill_reg == keff);
    assign emit = (fill_next == keff);

    // fill count after this sample
    always_comb
    begin
        fill_next = fill_reg;
        if (cfg_wr_en)
        begin
            fill_next = '0;
        end
        else if (load && !full)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    // window length and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RESET;
            fill_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wlen_reg <= cfg_wr_data;
            end
            fill_reg <= fill_next;
        end
    end

    // broadcast to the cells
    always_comb
    begin
        ctrl.load     = load;
        ctrl.clear    = cfg_wr_en;
        ctrl.full     = full;
        ctrl.age_last = IDX_W'(keff - CNT_W'(1));
        ctrl.sample   = s_axis_tdata[SAMPLE_WIDTH-1:0];
    end

    // row of sorted cells, lowest value at cell 0
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign dn_view[i] = '{value: '0, age: '0, valid: 1'b1, le: 1'b1};
            assign dn_ev[i]   = 1'b0;
        end
        else
        begin : g_rest
            assign dn_view[i] = ev_view[i-1];
            assign dn_ev[i]   = ev_chain[i-1];
        end
        if (i == WINDOW_MAX - 1)
        begin : g_top
            assign up_view[i] = '0;
        end
        else
        begin : g_mid
            assign up_view[i] = old_view[i+1];
        end

        swm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .up_old   (up_view[i]),
            .dn_view  (dn_view[i]),
            .dn_ev    (dn_ev[i]),
            .old_view (old_view[i]),
            .ev_view  (ev_view[i]),
            .ev_out   (ev_chain[i])
        );

        assign cell_value[i] = old_view[i].value;
        assign valid_vec[i]  = old_view[i].valid;
    end

    // median select and output register
    swm_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .emit       (emit),
        .keff       (keff),
        .cell_value (cell_value),
        .can_accept (can_accept),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_median (median)
    );

    assign m_axis_tdata = TDATA_W'(median);

    // the window never holds more than k entries
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= keff)
        else $error("fill count beyond window length");

    // valid cells track the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(fill_reg))
        else $error("valid cells disagree with fill count");

    // valid cells are packed at the bottom of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_vec + WINDOW_MAX'(1)))
        else $error("valid cells not contiguous from cell 0");

endmodule

`default_nettype wire

// File: design/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_cell
    import swm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire swm_ctrl_t ctrl,
    input  wire swm_view_t up_old,   // old contents of the next cell up
    input  wire swm_view_t dn_view,  // post-eviction view of the cell below
    input  wire logic      dn_ev,    // eviction at or below the cell below
    output swm_view_t      old_view,
    output swm_view_t      ev_view,  // this slot after the oldest entry is removed
    output logic           ev_out
);

    logic [SAMPLE_WIDTH-1:0] value_reg, value_next;
    logic [IDX_W-1:0]        age_reg, age_next;
    logic                    valid_reg, valid_next;

    // own contents and compare against the incoming sample
    always_comb
    begin
        old_view.value = value_reg;
        old_view.age   = age_reg;
        old_view.valid = valid_reg;
        old_view.le    = valid_reg && ($signed(value_reg) <= $signed(ctrl.sample));
    end

    // eviction: everything above the oldest entry slides down by one
    assign ev_out  = dn_ev || (ctrl.full && valid_reg && (age_reg == ctrl.age_last));
    assign ev_view = ev_out ? up_old : old_view;

    // insertion: keep, take the new sample, or take the entry from below
    always_comb
    begin
        value_next = value_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            if (ev_view.le)
            begin
                value_next = ev_view.value;
                age_next   = ev_view.age + IDX_W'(1);
                valid_next = 1'b1;
            end
            else if (dn_view.le)
            begin
                value_next = ctrl.sample;
                age_next   = '0;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = dn_view.value;
                age_next   = dn_view.age + IDX_W'(1);
                valid_next = dn_view.valid;
            end
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

`default_nettype wire

// File: design/swm_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_out_stage
    import swm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,       // sample transfer
    input  wire logic                    emit,       // that sample completes a window
    input  wire logic [CNT_W-1:0]        keff,
    input  wire logic [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX],
    output logic                         can_accept,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0]      out_median
);

    logic                    pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] median_reg;
    logic [CNT_W:0]          half;
    logic [IDX_W-1:0]        mid;
    logic                    move;

    // lower median position ceil(k/2)-1
    assign half = ((CNT_W + 1)'(keff) + (CNT_W + 1)'(1)) >> 1;
    assign mid  = IDX_W'(half - (CNT_W + 1)'(1));

    // pending result moves into the output register when it is free
    assign move       = pend_reg && (!out_valid_reg || out_ready);
    assign can_accept = !pend_reg || !out_valid_reg || out_ready;

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load && emit)
        begin
            pend_next = 1'b1;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pick the median out of the cells after the update
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            median_reg <= cell_value[mid];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_median = median_reg;

    // a waiting result and a stalled output block new samples
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && out_valid_reg && !out_ready) |-> !can_accept)
        else $error("sample taken while both result slots are held");

    // a completed window always leaves a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && emit) |=> pend_reg)
        else $error("completed window produced no pending result");

    // a stalled result stays in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(median_reg)))
        else $error("stalled median was dropped or changed");

endmodule

`default_nettype wire

// File: dv/tb_sliding_window_median_core.sv
`timescale 1ns / 1ps

module tb_sliding_window_median_core;
    import swm_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    localparam int IDLE_PCT    = 37;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 6;
    localparam int RANDOM_ITEMS = 1950;

    // running median predictor and store of medians still to arrive
    class median_scoreboard;
        logic [WLEN_W-1:0] wlen;
        sample_t arrivals[$];     // window contents, oldest first
        sample_t ranked[$];       // window contents, ascending
        sample_t medians_due[$];
        int failures;

        function new();
            wlen = WLEN_RESET;
            failures = 0;
        endfunction

        function int depth();
            int k;
            k = wlen;
            if (k == 0) k = 1;
            if (k > WINDOW_MAX) k = WINDOW_MAX;
            return k;
        endfunction

        // a length write empties the window
        function void set_window(logic [WLEN_W-1:0] len);
            wlen = len;
            arrivals.delete();
            ranked.delete();
        endfunction

        function void note_sample(sample_t s);
            int k;
            int pos;
            sample_t oldest;
            k = depth();
            // evict the oldest entry from both views
            if (arrivals.size() == k) begin
                oldest = arrivals.pop_front();
                pos = 0;
                while (ranked[pos] != oldest) pos++;
                ranked.delete(pos);
            end
            arrivals.push_back(s);
            // equal values go after existing ones
            pos = 0;
            while (pos < ranked.size() && ranked[pos] <= s) pos++;
            ranked.insert(pos, s);
            if (ranked.size() == k) medians_due.push_back(ranked[(k + 1) / 2 - 1]);
        endfunction

        function void check_median(logic [TDATA_W-1:0] got);
            sample_t want;
            if (medians_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected median transfer: got %0d", $signed(got));
                return;
            end
            want = medians_due.pop_front();
            if (got[SAMPLE_WIDTH-1:0] !== want) begin
                failures++;
                if (failures <= 10)
                    $display("median mismatch: expected %0d got %0d", want, $signed(got));
            end
        endfunction

        function int pending();
            return medians_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;    // sample
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;         // median
    logic cfg_wr_en = 1'b0;
    logic [WLEN_W-1:0] cfg_wr_data = '0;      // window_length

    median_scoreboard sb = new();
    bit no_stall = 1'b0;
    int idle_cycles = 0;
    int random_sent = 0;

    sliding_window_median_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // median sink with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_median(m_axis_tdata);
        m_axis_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end

    // cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // one sample transfer, with a random gap ahead of it
    task automatic send_sample(input sample_t v);
        if (!no_stall && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(v);
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_sample(v);
    endtask

    // hold the sender until every median has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // length write while idle
    task automatic write_window(input logic [WLEN_W-1:0] len);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        sb.set_window(len);
        cfg_wr_en <= 1'b0;
    endtask

    // mix of full-range, clustered and extreme samples
    function automatic sample_t pick_sample();
        int mode;
        mode = $urandom_range(99);
        if (mode < 40) return sample_t'($urandom);
        if (mode < 70) return sample_t'($urandom_range(16)) - 8;
        if (mode < 80) return sample_t'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}}) +
                              sample_t'($urandom_range(3));
        if (mode < 90) return sample_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}}) -
                              sample_t'($urandom_range(3));
        return sample_t'($urandom_range(3));
    endfunction

    task automatic random_phase(input logic [WLEN_W-1:0] len, input int count);
        int n;
        write_window(len);
        for (n = 0; n < count; n++) begin
            send_sample(pick_sample());
            random_sent++;
        end
    endtask

    initial
    begin
        sample_t smin;
        sample_t smax;
        int phase;
        int count;
        logic [WLEN_W-1:0] len;
        smin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        smax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset length of three, extremes and ties
        send_sample(smin);
        send_sample(smax);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(smax);
        send_sample(smax);
        send_sample(smax);
        send_sample(smin);
        send_sample(smin);
        send_sample(5);
        send_sample(5);
        send_sample(5);
        send_sample(-5);
        // single-sample window passes samples through
        write_window(WLEN_W'(1));
        send_sample(smin);
        send_sample(smax);
        send_sample(-1);
        // pair window gives the smaller one
        write_window(WLEN_W'(2));
        send_sample(smax);
        send_sample(smin);
        send_sample(7);
        send_sample(7);
        send_sample(-3);
        // zero length behaves as one
        write_window(WLEN_W'(0));
        send_sample(42);
        send_sample(smin);

        // random phases: fixed extremes first, then random lengths
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0: len = WLEN_W'(1);
                1: len = WLEN_W'(2);
                2: len = WLEN_W'(WINDOW_MAX);
                3: len = WLEN_W'(0);
                4: len = {WLEN_W{1'b1}};
                5: len = WLEN_W'(WINDOW_MAX + 1);
                default:
                begin
                    if ($urandom_range(9) < 7) len = WLEN_W'($urandom_range(9, 1));
                    else if ($urandom_range(1) == 0)
                        len = WLEN_W'($urandom_range(WINDOW_MAX, 1));
                    else len = WLEN_W'($urandom_range({WLEN_W{1'b1}}));
                end
            endcase
            // size the phase by the length about to be written
            count = (len > WLEN_W'(16)) ? $urandom_range(40, 100) + WINDOW_MAX
                                        : $urandom_range(20, 80);
            if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
            no_stall = (phase == 6);
            if (phase == 7) begin
                // pause the sender mid-phase until the output is empty
                random_phase(len, count / 2);
                drain();
                count = count - count / 2;
                for (int n = 0; n < count; n++) begin
                    send_sample(pick_sample());
                    random_sent++;
                end
            end
            else begin
                random_phase(len, count);
            end
            phase++;
        end
        no_stall = 1'b0;

        // let the last medians arrive
        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
